// ----- sv/sldf_pkg.sv -----
// Shared constants for the sync/length/CRC-32 packet deframer.
// Used by sldf_crc_byte and sync_length_crc_deframer_unit; no dependencies.
`timescale 1ns / 1ps

package sldf_pkg;

    localparam int LEN_W = 21;
    localparam int CNT_W = 21;

    localparam logic [7:0] SYNC_FIRST  = 8'h50;
    localparam logic [7:0] SYNC_SECOND = 8'h56;

    localparam logic [CNT_W-1:0] HEADER_BYTES = CNT_W'(8);
    localparam logic [CNT_W-1:0] TRAILER_BYTES = CNT_W'(4);

    // header byte positions counted from the first sync byte
    localparam logic [CNT_W-1:0] POS_SYNC2 = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_TYPE  = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_SEQ   = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_LEN0  = CNT_W'(4);
    localparam logic [CNT_W-1:0] POS_LEN1  = CNT_W'(5);
    localparam logic [CNT_W-1:0] POS_LEN2  = CNT_W'(6);
    localparam logic [CNT_W-1:0] POS_LEN3  = CNT_W'(7);

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = LEN_W'(16384);
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_CAP   = LEN_W'(1048576);

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [1:0] KIND_HEADER   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
    localparam logic [1:0] KIND_END_GOOD = 2'd2;
    localparam logic [1:0] KIND_END_BAD  = 2'd3;

    typedef struct packed {
        logic [LEN_W-1:0] payload_length;
        logic [7:0]       sequence_res;
        logic [7:0]       packet_type;
        logic [7:0]       data_byte;
    } result_t;

endpackage

// ----- sv/sync_length_crc_deframer_unit.sv -----
// Sync/length/CRC-32 packet deframer, one received byte per request.
// The block takes one byte per clock whenever s_tready is high: the whole
// parse step, including the bytewise CRC-32 update, sits between the accepted
// byte and a single result register. s_tready is low only while a finished
// result waits in that register and m_tready is low.
// It hunts for 'P','V', collects type, sequence and a 32-bit little-endian
// length, drops packets longer than max_payload (capped at 2^20) without any
// result, and otherwise emits a header result, one result per payload byte and
// a final good/bad result after checking the little-endian CRC-32 trailer.
// Depends on sldf_pkg and sldf_crc_byte.
`timescale 1ns / 1ps

module sync_length_crc_deframer_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [20:0] cfg_wr_data,   // max_payload

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,       // [7:0] data_byte, [15:8] packet_type,
                                       // [23:16] sequence_res,
                                       // [44:24] payload_length, [47:45] zero
    output logic [1:0]  m_tuser        // [1:0] kind
);

    localparam int LEN_W = sldf_pkg::LEN_W;
    localparam int CNT_W = sldf_pkg::CNT_W;

    logic [LEN_W-1:0] max_payload_reg;

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [CNT_W-1:0] expected_total_reg, expected_total_next;
    logic [CNT_W-1:0] payload_end_reg, payload_end_next;
    logic [31:0]      running_crc_reg, running_crc_next;
    logic [7:0]       held_type_reg, held_type_next;
    logic [7:0]       held_sequence_reg, held_sequence_next;
    logic [LEN_W-1:0] held_length_reg, held_length_next;
    logic             length_high_reg, length_high_next;
    logic [31:0]      trailer_shift_reg, trailer_shift_next;

    logic                  out_valid_reg;
    logic [1:0]            out_kind_reg;
    sldf_pkg::result_t     out_data_reg;

    logic                  emit;
    logic [1:0]            emit_kind;
    logic [7:0]            emit_byte;
    logic [31:0]           crc_upd;
    logic [LEN_W-1:0]      limit;
    logic                  accept;
    logic [CNT_W-1:0]      count_inc;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign limit    = (max_payload_reg > sldf_pkg::MAX_PAYLOAD_CAP) ?
                      sldf_pkg::MAX_PAYLOAD_CAP : max_payload_reg;
    assign count_inc = byte_count_reg + CNT_W'(1);

    sldf_crc_byte u_crc
    (
        .crc_in  (running_crc_reg),
        .data_in (s_tdata),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        byte_count_next     = byte_count_reg;
        expected_total_next = expected_total_reg;
        payload_end_next    = payload_end_reg;
        running_crc_next    = running_crc_reg;
        held_type_next      = held_type_reg;
        held_sequence_next  = held_sequence_reg;
        held_length_next    = held_length_reg;
        length_high_next    = length_high_reg;
        trailer_shift_next  = trailer_shift_reg;
        emit                = 1'b0;
        emit_kind           = sldf_pkg::KIND_HEADER;
        emit_byte           = 8'd0;

        if (accept)
        begin
            if (byte_count_reg == '0)
            begin
                if (s_tdata == sldf_pkg::SYNC_FIRST)
                begin
                    byte_count_next    = CNT_W'(1);
                    running_crc_next   = sldf_pkg::CRC_INIT;
                    held_length_next   = '0;
                    length_high_next   = 1'b0;
                    trailer_shift_next = '0;
                end
            end
            else if (byte_count_reg == sldf_pkg::POS_SYNC2)
            begin
                // a repeated 'P' counts as a new first sync byte, so the hunt waits for 'V' again
                if (s_tdata == sldf_pkg::SYNC_SECOND)
                    byte_count_next = CNT_W'(2);
                else if (s_tdata == sldf_pkg::SYNC_FIRST)
                    byte_count_next = CNT_W'(1);
                else
                    byte_count_next = '0;
            end
            else if (byte_count_reg < sldf_pkg::HEADER_BYTES)
            begin
                running_crc_next = crc_upd;
                byte_count_next  = count_inc;
                if (byte_count_reg == sldf_pkg::POS_TYPE)
                    held_type_next = s_tdata;
                else if (byte_count_reg == sldf_pkg::POS_SEQ)
                    held_sequence_next = s_tdata;
                else if (byte_count_reg == sldf_pkg::POS_LEN0)
                    held_length_next[7:0] = held_length_reg[7:0] | s_tdata;
                else if (byte_count_reg == sldf_pkg::POS_LEN1)
                    held_length_next[15:8] = held_length_reg[15:8] | s_tdata;
                else if (byte_count_reg == sldf_pkg::POS_LEN2)
                begin
                    held_length_next[20:16] = held_length_reg[20:16] | s_tdata[4:0];
                    length_high_next = length_high_reg || (s_tdata[7:5] != 3'd0);
                end
                else
                    length_high_next = length_high_reg || (s_tdata != 8'd0);

                if (byte_count_reg == sldf_pkg::POS_LEN3)
                begin
                    // drop oversized packets silently and resume the hunt
                    if (length_high_next || (held_length_next > limit))
                    begin
                        byte_count_next     = '0;
                        expected_total_next = sldf_pkg::HEADER_BYTES;
                    end
                    else
                    begin
                        payload_end_next    = held_length_next + sldf_pkg::HEADER_BYTES;
                        expected_total_next = held_length_next + sldf_pkg::HEADER_BYTES
                                              + sldf_pkg::TRAILER_BYTES;
                        emit      = 1'b1;
                        emit_kind = sldf_pkg::KIND_HEADER;
                    end
                end
            end
            else
            begin
                byte_count_next = count_inc;
                if (byte_count_reg < payload_end_reg)
                begin
                    running_crc_next = crc_upd;
                    emit      = 1'b1;
                    emit_kind = sldf_pkg::KIND_PAYLOAD;
                    emit_byte = s_tdata;
                end
                else
                begin
                    trailer_shift_next = {s_tdata, trailer_shift_reg[31:8]};
                    if (count_inc >= expected_total_reg)
                    begin
                        emit      = 1'b1;
                        emit_kind = (trailer_shift_next == ~running_crc_reg) ?
                                    sldf_pkg::KIND_END_GOOD : sldf_pkg::KIND_END_BAD;
                        byte_count_next     = '0;
                        expected_total_next = sldf_pkg::HEADER_BYTES;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg    <= sldf_pkg::MAX_PAYLOAD_RESET;
            byte_count_reg     <= '0;
            expected_total_reg <= sldf_pkg::HEADER_BYTES;
            payload_end_reg    <= sldf_pkg::HEADER_BYTES;
            running_crc_reg    <= sldf_pkg::CRC_INIT;
            held_type_reg      <= '0;
            held_sequence_reg  <= '0;
            held_length_reg    <= '0;
            length_high_reg    <= 1'b0;
            trailer_shift_reg  <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                max_payload_reg <= cfg_wr_data;
            byte_count_reg     <= byte_count_next;
            expected_total_reg <= expected_total_next;
            payload_end_reg    <= payload_end_next;
            running_crc_reg    <= running_crc_next;
            held_type_reg      <= held_type_next;
            held_sequence_reg  <= held_sequence_next;
            held_length_reg    <= held_length_next;
            length_high_reg    <= length_high_next;
            trailer_shift_reg  <= trailer_shift_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded only when a new result is produced
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_kind_reg                <= emit_kind;
            out_data_reg.data_byte      <= emit_byte;
            out_data_reg.packet_type    <= held_type_next;
            out_data_reg.sequence_res   <= held_sequence_next;
            out_data_reg.payload_length <= held_length_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {3'd0, out_data_reg};

endmodule

// ----- sv/sldf_crc_byte.sv -----
// Bytewise reflected CRC-32 update (zlib polynomial), purely combinational.
// Depends on sldf_pkg for the polynomial.
`timescale 1ns / 1ps

module sldf_crc_byte
(
    input  logic [31:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [31:0] crc_out
);

    always_comb
    begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data_in};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ sldf_pkg::CRC_POLY;
            else
                c = c >> 1;
        end
        crc_out = c;
    end

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for sync_length_crc_deframer_unit: random packet streams
// with random sender gaps and receiver stalls, checked against a bytewise parser model.
// Depends on sldf_pkg and the deframer RTL.
`timescale 1ns / 1ps

typedef struct {
    logic [1:0]         kind;
    sldf_pkg::result_t  fields;
} frame_event_t;

class packet_scoreboard;
    logic [sldf_pkg::LEN_W-1:0] max_len;
    logic [sldf_pkg::CNT_W-1:0] hunt_pos;
    logic [sldf_pkg::CNT_W-1:0] frame_end;
    logic [31:0]      crc_acc;
    logic [31:0]      hdr_len;
    logic [31:0]      crc_trailer;
    logic [7:0]       hdr_type;
    logic [7:0]       hdr_seq;
    frame_event_t     expected_results[$];
    int unsigned      errors;
    int unsigned      n_checked;

    function new();
        max_len     = sldf_pkg::MAX_PAYLOAD_RESET;
        hunt_pos    = '0;
        frame_end   = sldf_pkg::HEADER_BYTES;
        crc_acc     = sldf_pkg::CRC_INIT;
        hdr_len     = '0;
        crc_trailer = '0;
        hdr_type    = '0;
        hdr_seq     = '0;
        errors      = 0;
        n_checked   = 0;
    endfunction

    static function logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ sldf_pkg::CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function void set_max(input logic [sldf_pkg::LEN_W-1:0] v);
        max_len = v;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    function void push_event(input logic [1:0] kind, input logic [7:0] data);
        frame_event_t ev;
        ev.kind                  = kind;
        ev.fields.data_byte      = data;
        ev.fields.packet_type    = hdr_type;
        ev.fields.sequence_res   = hdr_seq;
        ev.fields.payload_length = hdr_len[sldf_pkg::LEN_W-1:0];
        expected_results.push_back(ev);
    endfunction

    // advance the parser by one accepted byte
    function void note_byte(input logic [7:0] b);
        logic [sldf_pkg::LEN_W-1:0] lim;
        logic [sldf_pkg::CNT_W-1:0] pos;
        lim = (max_len > sldf_pkg::MAX_PAYLOAD_CAP) ? sldf_pkg::MAX_PAYLOAD_CAP : max_len;
        if (hunt_pos == '0)
        begin
            if (b == sldf_pkg::SYNC_FIRST)
            begin
                hunt_pos    = sldf_pkg::POS_SYNC2;
                crc_acc     = sldf_pkg::CRC_INIT;
                hdr_len     = '0;
                crc_trailer = '0;
            end
            return;
        end
        if (hunt_pos == sldf_pkg::POS_SYNC2)
        begin
            if (b == sldf_pkg::SYNC_SECOND)
                hunt_pos = sldf_pkg::POS_TYPE;
            else if (b == sldf_pkg::SYNC_FIRST)
                hunt_pos = sldf_pkg::POS_SYNC2;
            else
                hunt_pos = '0;
            return;
        end
        if (hunt_pos < sldf_pkg::HEADER_BYTES)
        begin
            crc_acc = crc_update(crc_acc, b);
            if (hunt_pos == sldf_pkg::POS_TYPE)
                hdr_type = b;
            else if (hunt_pos == sldf_pkg::POS_SEQ)
                hdr_seq = b;
            else
                hdr_len |= {24'h0, b} << (8 * (hunt_pos - sldf_pkg::POS_LEN0));
            hunt_pos++;
            if (hunt_pos < sldf_pkg::HEADER_BYTES)
                return;
            // drop oversized packets without a result
            if (hdr_len > {11'h0, lim})
            begin
                hunt_pos  = '0;
                frame_end = sldf_pkg::HEADER_BYTES;
                return;
            end
            frame_end = sldf_pkg::HEADER_BYTES + hdr_len[sldf_pkg::CNT_W-1:0]
                        + sldf_pkg::TRAILER_BYTES;
            push_event(sldf_pkg::KIND_HEADER, 8'h00);
            return;
        end
        pos = hunt_pos;
        hunt_pos++;
        if ({11'h0, pos} < {11'h0, sldf_pkg::HEADER_BYTES} + hdr_len)
        begin
            crc_acc = crc_update(crc_acc, b);
            push_event(sldf_pkg::KIND_PAYLOAD, b);
            return;
        end
        crc_trailer = {b, crc_trailer[31:8]};
        if (hunt_pos >= frame_end)
        begin
            push_event((crc_trailer == ~crc_acc) ? sldf_pkg::KIND_END_GOOD
                                                 : sldf_pkg::KIND_END_BAD, 8'h00);
            hunt_pos  = '0;
            frame_end = sldf_pkg::HEADER_BYTES;
        end
    endfunction

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        if (errors <= 50)
            $display("mismatch on result %0d: %s got 0x%0h want 0x%0h",
                     n_checked, what, got, want);
    endtask

    task check_result(input logic [1:0] kind, input logic [47:0] tdata);
        frame_event_t      want;
        sldf_pkg::result_t got;
        n_checked++;
        if (expected_results.size() == 0)
        begin
            report_mismatch("unexpected result, kind", {30'h0, kind}, 32'h0);
            return;
        end
        want = expected_results.pop_front();
        got  = sldf_pkg::result_t'(tdata[44:0]);
        if (kind != want.kind)
            report_mismatch("kind", {30'h0, kind}, {30'h0, want.kind});
        if (got.data_byte != want.fields.data_byte)
            report_mismatch("data_byte", {24'h0, got.data_byte},
                            {24'h0, want.fields.data_byte});
        if (got.packet_type != want.fields.packet_type)
            report_mismatch("packet_type", {24'h0, got.packet_type},
                            {24'h0, want.fields.packet_type});
        if (got.sequence_res != want.fields.sequence_res)
            report_mismatch("sequence_res", {24'h0, got.sequence_res},
                            {24'h0, want.fields.sequence_res});
        if (got.payload_length != want.fields.payload_length)
            report_mismatch("payload_length", {11'h0, got.payload_length},
                            {11'h0, want.fields.payload_length});
        if (tdata[47:45] != 3'b000)
            report_mismatch("tdata padding", {29'h0, tdata[47:45]}, 32'h0);
    endtask
endclass

module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 80;
    localparam int LEN_W       = sldf_pkg::LEN_W;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [20:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    packet_scoreboard sb = new();

    logic [7:0]       stim[$];
    logic [LEN_W-1:0] cur_max;
    int               burst_left;
    int               bytes_sent;
    int               cycles;

    sync_length_crc_deframer_unit uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // check outgoing results before noting the incoming byte of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata);
        end
    end

    // receiver: switch between always ready, coin flip and mostly stalled
    initial
    begin
        int mode;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(20, 80))
            begin
                @(negedge clk);
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = 1'($urandom_range(0, 1));
                    default: m_tready = ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    function automatic logic [31:0] eff_limit();
        return {11'h0, (cur_max > sldf_pkg::MAX_PAYLOAD_CAP) ? sldf_pkg::MAX_PAYLOAD_CAP
                                                              : cur_max};
    endfunction

    function automatic logic [31:0] pick_length(input logic [31:0] lim);
        int          r;
        logic [31:0] len;
        logic [31:0] top;
        r   = $urandom_range(0, 99);
        top = (lim < 24) ? lim : 32'd24;
        if (r < 15)
        begin
            len = $urandom;
            if (len <= lim)
                len = lim + 1 + $urandom_range(0, 3);
        end
        else if (r < 25)
            len = (lim <= 64) ? lim : top;
        else if (r < 28 && lim >= 300)
            len = $urandom_range(100, 300);
        else
            len = $urandom_range(0, top);
        return len;
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom);
        // keep stray second sync bytes out so noise cannot start a bogus header
        if (b == sldf_pkg::SYNC_SECOND || $urandom_range(0, 3) == 0)
            b = sldf_pkg::SYNC_FIRST;
        return b;
    endfunction

    task automatic add_packet(input logic [7:0] ty, input logic [7:0] sq,
                              input logic [31:0] len, input bit bad_crc, input bit mangle);
        logic [7:0]  frame[$];
        logic [31:0] crc;
        logic [7:0]  b;
        int          cut;
        frame = {sldf_pkg::SYNC_FIRST, sldf_pkg::SYNC_SECOND, ty, sq,
                 len[7:0], len[15:8], len[23:16], len[31:24]};
        crc   = sldf_pkg::CRC_INIT;
        for (int i = 2; i < 8; i++)
            crc = sb.crc_update(crc, frame[i]);
        if (len <= eff_limit())
        begin
            for (int i = 0; i < int'(len); i++)
            begin
                b = 8'($urandom);
                frame.push_back(b);
                crc = sb.crc_update(crc, b);
            end
            crc = ~crc;
            if (bad_crc)
                crc[$urandom_range(0, 31)] ^= 1'b1;
            frame.push_back(crc[7:0]);
            frame.push_back(crc[15:8]);
            frame.push_back(crc[23:16]);
            frame.push_back(crc[31:24]);
            // scramble the tail past the header; the length stays intact
            if (mangle)
            begin
                cut = $urandom_range(8, frame.size() - 1);
                for (int i = cut; i < frame.size(); i++)
                    frame[i] = 8'($urandom);
            end
        end
        foreach (frame[i])
            stim.push_back(frame[i]);
    endtask

    task automatic push_byte(input logic [7:0] b);
        if (burst_left == 0)
        begin
            s_tvalid = 1'b0;
            repeat (($urandom_range(0, 5) == 0) ? 8 : $urandom_range(1, 4))
                @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic send_queued();
        while (stim.size() != 0)
        begin
            push_byte(stim.pop_front());
            bytes_sent++;
        end
    endtask

    // hold the sender until every expected result has drained
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_max_payload(input logic [LEN_W-1:0] v);
        wait_idle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        cur_max   = v;
        sb.set_max(v);
    endtask

    initial
    begin
        int  r;
        int  phase_start;
        bit  paused;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cur_max     = sldf_pkg::MAX_PAYLOAD_RESET;
        burst_left  = 0;
        bytes_sent  = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // noise, a broken sync pair, a repeated first sync byte into an empty packet,
        // then an oversized header under the reset limit
        stim = {8'h00, 8'hFF, sldf_pkg::SYNC_FIRST, 8'h41, sldf_pkg::SYNC_FIRST};
        add_packet(8'hFF, 8'h00, 32'h0000_0000, 1'b0, 1'b0);
        add_packet(8'h00, 8'hFF, 32'h0000_4001, 1'b0, 1'b0);
        send_queued();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1: write_max_payload('0);
                2: write_max_payload(sldf_pkg::MAX_PAYLOAD_CAP);
                3: write_max_payload(21'h1F_FFFF);
                4: write_max_payload(LEN_W'($urandom_range(1, 40)));
                default: ;
            endcase
            phase_start = bytes_sent;
            paused      = 1'b0;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    add_packet(8'($urandom), 8'($urandom), pick_length(eff_limit()),
                               $urandom_range(0, 3) == 0, 1'b0);
                else if (r < 80)
                    repeat ($urandom_range(1, 4)) stim.push_back(noise_byte());
                else if (r < 88)
                begin
                    stim.push_back(sldf_pkg::SYNC_FIRST);
                    stim.push_back(noise_byte());
                end
                else
                    add_packet(8'($urandom), 8'($urandom), pick_length(eff_limit()),
                               1'b0, 1'b1);
                send_queued();
                if (!paused && bytes_sent - phase_start > PHASE_BYTES / 2)
                begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
        end

        wait_idle();
        repeat (8) @(negedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/sldf_pkg.sv
sv/sldf_crc_byte.sv
sv/sync_length_crc_deframer_unit.sv
dv/testbench.sv
